>>> rtl/core/rabs_pkg.sv
// ----------------------------------------------------------------------------
// rabs_pkg
// Shared widths and constants for the 2d ray versus box slab test.
// ----------------------------------------------------------------------------
package rabs_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int DIR_WIDTH       = 16;
    localparam int DIR_SHIFT       = 14;
    localparam int DIR_ONE         = 16384;
    localparam int TOL_WIDTH       = 16;
    localparam int DIV_BITS        = 4;

    localparam logic [TOL_WIDTH-1:0] TOL_RESET = 16'd1;

    localparam logic signed [DIR_WIDTH-1:0] NORM_POS  = 16'sd16384;
    localparam logic signed [DIR_WIDTH-1:0] NORM_NEG  = -16'sd16384;
    localparam logic signed [DIR_WIDTH-1:0] NORM_ZERO = 16'sd0;

endpackage

>>> rtl/core/ray_aabb_slab_test_2d.sv
// ----------------------------------------------------------------------------
// ray_aabb_slab_test_2d
// Tests one 2d ray against one axis-aligned box per cycle.
// ----------------------------------------------------------------------------
// Usage:
// - raise start with a ray and a box on the input ports; the item is taken at
//   the edge where start is high and busy is low. busy stays low, so a new
//   item may be given in every cycle.
// - each result is shown for one cycle with done high. an accepted item passes
//   the input register, stage b, the crossing-distance dividers, whose depth
//   is S = ceil((COORD_WIDTH + 15) / 4), and then stages c to g, in that order.
//   throughput is one item a cycle.
// - the four crossing distances each go through their own pipelined divider
//   that retires four quotient bits per stage; that sets the latency.
// - face_tolerance is written over the cfg channel (cfg_ready is always high)
//   and should only change while no item is in flight.
// - reset clears every valid bit and sets face_tolerance to 1.
// - the receiver cannot stall: results are not held back.
// ----------------------------------------------------------------------------
module ray_aabb_slab_test_2d #(
    parameter int COORD_WIDTH = rabs_pkg::COORD_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [COORD_WIDTH-1:0]         start_x,
    input  logic signed [COORD_WIDTH-1:0]         start_y,
    input  logic signed [rabs_pkg::DIR_WIDTH-1:0] dir_x,
    input  logic signed [rabs_pkg::DIR_WIDTH-1:0] dir_y,
    input  logic [COORD_WIDTH-2:0]                ray_length,
    input  logic signed [COORD_WIDTH-1:0]         box_min_x,
    input  logic signed [COORD_WIDTH-1:0]         box_min_y,
    input  logic signed [COORD_WIDTH-1:0]         box_max_x,
    input  logic signed [COORD_WIDTH-1:0]         box_max_y,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [rabs_pkg::TOL_WIDTH-1:0]        cfg_data,
    output logic                                  done,
    output logic                                  hit,
    output logic                                  started_inside,
    output logic [COORD_WIDTH-2:0]                hit_distance,
    output logic signed [COORD_WIDTH-1:0]         hit_x,
    output logic signed [COORD_WIDTH-1:0]         hit_y,
    output logic signed [rabs_pkg::DIR_WIDTH-1:0] normal_x,
    output logic signed [rabs_pkg::DIR_WIDTH-1:0] normal_y
);
    import rabs_pkg::*;

    localparam int CW     = COORD_WIDTH;
    localparam int LW     = CW - 1;
    localparam int NW     = CW + DIR_SHIFT + 1;
    localparam int QW     = NW + 1;
    localparam int PW     = DIR_WIDTH + LW + 1;
    localparam int SW     = PW - DIR_SHIFT;
    localparam int STAGES = (NW + DIV_BITS - 1) / DIV_BITS;

    typedef struct packed {
        logic signed [CW-1:0]        sx;
        logic signed [CW-1:0]        sy;
        logic signed [DIR_WIDTH-1:0] dx;
        logic signed [DIR_WIDTH-1:0] dy;
        logic [LW-1:0]               len;
        logic signed [CW-1:0]        lox;
        logic signed [CW-1:0]        hix;
        logic signed [CW-1:0]        loy;
        logic signed [CW-1:0]        hiy;
        logic                        in_box;
        logic                        okx;
        logic                        oky;
        logic [3:0]                  neg;
    } side_t;

    // configuration
    logic [TOL_WIDTH-1:0] tol_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= TOL_RESET;
        else if (cfg_valid)
            tol_reg <= cfg_data;
    end

    // stage a: input register
    logic                        a_valid_reg;
    logic signed [CW-1:0]        a_sx_reg, a_sy_reg;
    logic signed [DIR_WIDTH-1:0] a_dx_reg, a_dy_reg;
    logic [LW-1:0]               a_len_reg;
    logic signed [CW-1:0]        a_ax_reg, a_ay_reg, a_bx_reg, a_by_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else
            a_valid_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        a_sx_reg  <= start_x;
        a_sy_reg  <= start_y;
        a_dx_reg  <= dir_x;
        a_dy_reg  <= dir_y;
        a_len_reg <= ray_length;
        a_ax_reg  <= box_min_x;
        a_ay_reg  <= box_min_y;
        a_bx_reg  <= box_max_x;
        a_by_reg  <= box_max_y;
    end

    // stage b: sort corners, inside test, divider operands
    side_t                b_side_next;
    logic signed [CW:0]   diff [4];
    logic signed [NW-1:0] scaled [4];
    logic [NW-1:0]        num_next [4];
    logic [DIR_WIDTH-1:0] den_x, den_y;

    always_comb
    begin
        b_side_next.sx  = a_sx_reg;
        b_side_next.sy  = a_sy_reg;
        b_side_next.dx  = a_dx_reg;
        b_side_next.dy  = a_dy_reg;
        b_side_next.len = a_len_reg;
        b_side_next.lox = (a_ax_reg < a_bx_reg) ? a_ax_reg : a_bx_reg;
        b_side_next.hix = (a_ax_reg < a_bx_reg) ? a_bx_reg : a_ax_reg;
        b_side_next.loy = (a_ay_reg < a_by_reg) ? a_ay_reg : a_by_reg;
        b_side_next.hiy = (a_ay_reg < a_by_reg) ? a_by_reg : a_ay_reg;
        b_side_next.in_box = (b_side_next.lox < a_sx_reg) && (a_sx_reg < b_side_next.hix)
                          && (b_side_next.loy < a_sy_reg) && (a_sy_reg < b_side_next.hiy);
        // an axis with no direction only asks whether the start is in its slab
        b_side_next.okx = (a_dx_reg != '0)
                       || ((b_side_next.lox <= a_sx_reg) && (a_sx_reg <= b_side_next.hix));
        b_side_next.oky = (a_dy_reg != '0)
                       || ((b_side_next.loy <= a_sy_reg) && (a_sy_reg <= b_side_next.hiy));

        diff[0] = {b_side_next.lox[CW-1], b_side_next.lox} - {a_sx_reg[CW-1], a_sx_reg};
        diff[1] = {b_side_next.hix[CW-1], b_side_next.hix} - {a_sx_reg[CW-1], a_sx_reg};
        diff[2] = {b_side_next.loy[CW-1], b_side_next.loy} - {a_sy_reg[CW-1], a_sy_reg};
        diff[3] = {b_side_next.hiy[CW-1], b_side_next.hiy} - {a_sy_reg[CW-1], a_sy_reg};

        for (int i = 0; i < 4; i++)
        begin
            scaled[i]   = {diff[i], {DIR_SHIFT{1'b0}}};
            num_next[i] = scaled[i][NW-1] ? NW'(-scaled[i]) : NW'(scaled[i]);
        end

        b_side_next.neg[0] = scaled[0][NW-1] ^ a_dx_reg[DIR_WIDTH-1];
        b_side_next.neg[1] = scaled[1][NW-1] ^ a_dx_reg[DIR_WIDTH-1];
        b_side_next.neg[2] = scaled[2][NW-1] ^ a_dy_reg[DIR_WIDTH-1];
        b_side_next.neg[3] = scaled[3][NW-1] ^ a_dy_reg[DIR_WIDTH-1];

        den_x = a_dx_reg[DIR_WIDTH-1] ? DIR_WIDTH'(-a_dx_reg) : DIR_WIDTH'(a_dx_reg);
        den_y = a_dy_reg[DIR_WIDTH-1] ? DIR_WIDTH'(-a_dy_reg) : DIR_WIDTH'(a_dy_reg);
    end

    logic                 b_valid_reg;
    side_t                b_side_reg;
    logic [NW-1:0]        b_num_reg [4];
    logic [DIR_WIDTH-1:0] b_denx_reg, b_deny_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        b_side_reg <= b_side_next;
        b_num_reg  <= num_next;
        b_denx_reg <= den_x;
        b_deny_reg <= den_y;
    end

    // crossing distances
    logic [NW-1:0] quo [4];
    logic [3:0]    div_valid;

    genvar g;
    generate
        for (g = 0; g < 4; g++)
        begin : g_div
            rabs_div #(
                .NUM_WIDTH (NW)
            ) u_div (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (b_valid_reg),
                .num       (b_num_reg[g]),
                .den       ((g < 2) ? b_denx_reg : b_deny_reg),
                .out_valid (div_valid[g]),
                .quo       (quo[g])
            );
        end
    endgenerate

    side_t side_reg [STAGES];

    always_ff @(posedge clk)
    begin
        side_reg[0] <= b_side_reg;
        for (int i = 1; i < STAGES; i++)
            side_reg[i] <= side_reg[i-1];
    end

    side_t div_side;
    assign div_side = side_reg[STAGES-1];

    // stage c: signs and ordering per axis
    logic signed [QW-1:0] sq [4];
    logic signed [QW-1:0] c_xl_next, c_xh_next, c_yl_next, c_yh_next;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
            sq[i] = div_side.neg[i] ? -$signed({1'b0, quo[i]}) : $signed({1'b0, quo[i]});
        c_xl_next = (sq[0] > sq[1]) ? sq[1] : sq[0];
        c_xh_next = (sq[0] > sq[1]) ? sq[0] : sq[1];
        c_yl_next = (sq[2] > sq[3]) ? sq[3] : sq[2];
        c_yh_next = (sq[2] > sq[3]) ? sq[2] : sq[3];
    end

    logic                 c_valid_reg;
    side_t                c_side_reg;
    logic signed [QW-1:0] c_xl_reg, c_xh_reg, c_yl_reg, c_yh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_valid_reg <= 1'b0;
        else
            c_valid_reg <= &div_valid;
    end

    always_ff @(posedge clk)
    begin
        c_side_reg <= div_side;
        c_xl_reg   <= c_xl_next;
        c_xh_reg   <= c_xh_next;
        c_yl_reg   <= c_yl_next;
        c_yh_reg   <= c_yh_next;
    end

    // stage d: entry and exit
    logic signed [QW-1:0] ent, ext;
    logic                 d_hit_next;

    always_comb
    begin
        ent = '0;
        ext = $signed({{(QW-LW){1'b0}}, c_side_reg.len});
        if (c_side_reg.dx != '0)
        begin
            if (c_xl_reg > ent)
                ent = c_xl_reg;
            if (c_xh_reg < ext)
                ext = c_xh_reg;
        end
        if (c_side_reg.dy != '0)
        begin
            if (c_yl_reg > ent)
                ent = c_yl_reg;
            if (c_yh_reg < ext)
                ext = c_yh_reg;
        end
        d_hit_next = c_side_reg.okx && c_side_reg.oky && (ent <= ext);
    end

    logic          d_valid_reg;
    side_t         d_side_reg;
    logic          d_hit_reg;
    logic [LW-1:0] d_entry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_valid_reg <= 1'b0;
        else
            d_valid_reg <= c_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        d_side_reg  <= c_side_reg;
        d_hit_reg   <= d_hit_next;
        d_entry_reg <= ent[LW-1:0];
    end

    // stage e: direction times entry
    logic signed [PW-1:0] prod_x, prod_y;

    assign prod_x = d_side_reg.dx * $signed({1'b0, d_entry_reg});
    assign prod_y = d_side_reg.dy * $signed({1'b0, d_entry_reg});

    logic                 e_valid_reg;
    side_t                e_side_reg;
    logic                 e_hit_reg;
    logic [LW-1:0]        e_entry_reg;
    logic signed [PW-1:0] e_px_reg, e_py_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e_valid_reg <= 1'b0;
        else
            e_valid_reg <= d_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        e_side_reg  <= d_side_reg;
        e_hit_reg   <= d_hit_reg;
        e_entry_reg <= d_entry_reg;
        e_px_reg    <= prod_x;
        e_py_reg    <= prod_y;
    end

    // stage f: scale toward zero, add start, saturate
    logic signed [PW-1:0] adj_x, adj_y;
    logic signed [SW-1:0] step_x, step_y;
    logic signed [CW+2:0] sum_x, sum_y;
    logic signed [CW-1:0] f_px_next, f_py_next;

    always_comb
    begin
        adj_x  = e_px_reg + (e_px_reg[PW-1] ? PW'(DIR_ONE - 1) : PW'(0));
        adj_y  = e_py_reg + (e_py_reg[PW-1] ? PW'(DIR_ONE - 1) : PW'(0));
        step_x = adj_x[PW-1:DIR_SHIFT];
        step_y = adj_y[PW-1:DIR_SHIFT];
        sum_x  = {{3{e_side_reg.sx[CW-1]}}, e_side_reg.sx} + {step_x[SW-1], step_x};
        sum_y  = {{3{e_side_reg.sy[CW-1]}}, e_side_reg.sy} + {step_y[SW-1], step_y};

        if (sum_x[CW+2:CW-1] == '0 || sum_x[CW+2:CW-1] == '1)
            f_px_next = sum_x[CW-1:0];
        else
            f_px_next = sum_x[CW+2] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};

        if (sum_y[CW+2:CW-1] == '0 || sum_y[CW+2:CW-1] == '1)
            f_py_next = sum_y[CW-1:0];
        else
            f_py_next = sum_y[CW+2] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end

    logic                 f_valid_reg;
    side_t                f_side_reg;
    logic                 f_hit_reg;
    logic [LW-1:0]        f_entry_reg;
    logic signed [CW-1:0] f_px_reg, f_py_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_valid_reg <= 1'b0;
        else
            f_valid_reg <= e_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        f_side_reg  <= e_side_reg;
        f_hit_reg   <= e_hit_reg;
        f_entry_reg <= e_entry_reg;
        f_px_reg    <= f_px_next;
        f_py_reg    <= f_py_next;
    end

    // stage g: face normal and result select
    logic signed [CW:0]          fd [4];
    logic [CW:0]                 fa [4];
    logic [3:0]                  on_face;
    logic signed [DIR_WIDTH-1:0] nx, ny;

    logic                        hit_next, inside_next;
    logic [LW-1:0]               dist_next;
    logic signed [CW-1:0]        hx_next, hy_next;
    logic signed [DIR_WIDTH-1:0] nx_next, ny_next;

    always_comb
    begin
        fd[0] = {f_px_reg[CW-1], f_px_reg} - {f_side_reg.lox[CW-1], f_side_reg.lox};
        fd[1] = {f_px_reg[CW-1], f_px_reg} - {f_side_reg.hix[CW-1], f_side_reg.hix};
        fd[2] = {f_py_reg[CW-1], f_py_reg} - {f_side_reg.loy[CW-1], f_side_reg.loy};
        fd[3] = {f_py_reg[CW-1], f_py_reg} - {f_side_reg.hiy[CW-1], f_side_reg.hiy};
        for (int i = 0; i < 4; i++)
        begin
            fa[i]      = fd[i][CW] ? (CW+1)'(-fd[i]) : (CW+1)'(fd[i]);
            on_face[i] = fa[i] < (CW+1)'(tol_reg);
        end

        // later faces win
        nx = NORM_ZERO;
        ny = NORM_ZERO;
        if (on_face[0])
        begin
            nx = NORM_NEG;
            ny = NORM_ZERO;
        end
        if (on_face[1])
        begin
            nx = NORM_POS;
            ny = NORM_ZERO;
        end
        if (on_face[2])
        begin
            nx = NORM_ZERO;
            ny = NORM_NEG;
        end
        if (on_face[3])
        begin
            nx = NORM_ZERO;
            ny = NORM_POS;
        end

        if (f_side_reg.in_box)
        begin
            hit_next    = 1'b1;
            inside_next = 1'b1;
            dist_next   = '0;
            hx_next     = f_side_reg.sx;
            hy_next     = f_side_reg.sy;
            nx_next     = -f_side_reg.dx;
            ny_next     = -f_side_reg.dy;
        end
        else if (f_hit_reg)
        begin
            hit_next    = 1'b1;
            inside_next = 1'b0;
            dist_next   = f_entry_reg;
            hx_next     = f_px_reg;
            hy_next     = f_py_reg;
            nx_next     = nx;
            ny_next     = ny;
        end
        else
        begin
            hit_next    = 1'b0;
            inside_next = 1'b0;
            dist_next   = '0;
            hx_next     = '0;
            hy_next     = '0;
            nx_next     = NORM_ZERO;
            ny_next     = NORM_ZERO;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done <= 1'b0;
        else
            done <= f_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        hit            <= hit_next;
        started_inside <= inside_next;
        hit_distance   <= dist_next;
        hit_x          <= hx_next;
        hit_y          <= hy_next;
        normal_x       <= nx_next;
        normal_y       <= ny_next;
    end

endmodule

>>> rtl/core/rabs_div.sv
// ----------------------------------------------------------------------------
// rabs_div
// Pipelined unsigned restoring divider, DIV_BITS quotient bits per stage.
// ----------------------------------------------------------------------------
module rabs_div #(
    parameter int NUM_WIDTH = 47
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic [NUM_WIDTH-1:0]            num,
    input  logic [rabs_pkg::DIR_WIDTH-1:0]  den,
    output logic                            out_valid,
    output logic [NUM_WIDTH-1:0]            quo
);
    import rabs_pkg::*;

    localparam int STAGES = (NUM_WIDTH + DIV_BITS - 1) / DIV_BITS;
    localparam int WW     = STAGES * DIV_BITS;

    logic [WW-1:0]        work_in   [STAGES];
    logic [DIR_WIDTH-1:0] rem_in    [STAGES];
    logic [DIR_WIDTH-1:0] den_in    [STAGES];
    logic                 valid_in  [STAGES];
    logic [WW-1:0]        work_next [STAGES];
    logic [DIR_WIDTH-1:0] rem_next  [STAGES];
    logic [WW-1:0]        work_reg  [STAGES];
    logic [DIR_WIDTH-1:0] rem_reg   [STAGES];
    logic [DIR_WIDTH-1:0] den_reg   [STAGES];
    logic                 valid_reg [STAGES];

    genvar s;
    generate
        for (s = 0; s < STAGES; s++)
        begin : g_stage
            if (s == 0)
            begin : g_first
                assign work_in[s]  = WW'(num);
                assign rem_in[s]   = '0;
                assign den_in[s]   = den;
                assign valid_in[s] = in_valid;
            end
            else
            begin : g_rest
                assign work_in[s]  = work_reg[s-1];
                assign rem_in[s]   = rem_reg[s-1];
                assign den_in[s]   = den_reg[s-1];
                assign valid_in[s] = valid_reg[s-1];
            end

            always_comb
            begin
                logic [WW-1:0]        w;
                logic [DIR_WIDTH:0]   t;
                logic [DIR_WIDTH-1:0] r;
                w = work_in[s];
                r = rem_in[s];
                for (int k = 0; k < DIV_BITS; k++)
                begin
                    t = {r, w[WW-1]};
                    w = {w[WW-2:0], 1'b0};
                    if (t >= {1'b0, den_in[s]})
                    begin
                        t    = t - {1'b0, den_in[s]};
                        w[0] = 1'b1;
                    end
                    r = t[DIR_WIDTH-1:0];
                end
                work_next[s] = w;
                rem_next[s]  = r;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[s] <= 1'b0;
                else
                    valid_reg[s] <= valid_in[s];
            end

            always_ff @(posedge clk)
            begin
                work_reg[s] <= work_next[s];
                rem_reg[s]  <= rem_next[s];
                den_reg[s]  <= den_in[s];
            end
        end
    endgenerate

    assign out_valid = valid_reg[STAGES-1];
    assign quo       = work_reg[STAGES-1][NUM_WIDTH-1:0];

endmodule
